>>> rtl/bclh_pkg.sv
// Shared types, constants and helper functions for the bit crusher with lowpass and hold.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package bclh_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W  = 16;
  localparam int MEM_W     = 24;
  localparam int COEF_FRAC = 16;
  localparam int DEPTH_W   = 5;
  localparam int HOLD_W    = 6;
  localparam int GAIN_W    = 16;
  localparam int COEFB_W   = 17;
  localparam int COEFA_W   = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 18;

  // Serial multiplier: 24-bit signed multiplicand, 18-bit signed multiplier
  localparam int MUL_M_W = 24;
  localparam int MUL_R_W = 18;
  localparam int MUL_P_W = MUL_M_W + 1 + MUL_R_W;
  localparam int ACC_W   = MUL_P_W + 1;

  // Defaults and limits
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int MAX_HOLD         = 50;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A      = 3'd4;

  // Reset values of the registers
  localparam logic [DEPTH_W-1:0]        BIT_DEPTH_RST   = 5'd16;
  localparam logic [HOLD_W-1:0]         HOLD_PERIOD_RST = 6'd0;
  localparam logic [GAIN_W-1:0]         MIX_GAIN_RST    = 16'd32768;
  localparam logic [COEFB_W-1:0]        COEF_B_RST      = 17'd65536;
  localparam logic signed [COEFA_W-1:0] COEF_A_RST      = 18'sd65536;

  localparam int MEM_MAX = (2 ** (MEM_W - 1)) - 1;
  localparam int SMP_MAX = (2 ** (SAMPLE_W - 1)) - 1;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic                      chan;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                      block_start;
  } in_word_t;

  typedef struct packed {
    logic                      chan_out;
    logic signed [SAMPLE_W-1:0] sample_out;
  } out_word_t;

  // Multiplier request and response
  typedef struct packed {
    logic                      start;
    logic signed [MUL_M_W-1:0] mcand;
    logic signed [MUL_R_W-1:0] mplr;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [MUL_P_W-1:0] product;
  } mul_rsp_t;

  // Clear the low bits so that depth fractional bits remain (floor)
  function automatic logic signed [SAMPLE_W-1:0] quantise(
    input logic signed [SAMPLE_W-1:0] x,
    input logic [DEPTH_W-1:0]         depth
  );
    logic [SAMPLE_W-1:0] mask;
    for (int i = 0; i < SAMPLE_W; i++) begin
      mask[i] = ((6'(i) + {1'b0, depth}) >= 6'(SAMPLE_W - 1));
    end
    return x & mask;
  endfunction

  // Saturate to the filter memory width
  function automatic logic signed [MEM_W-1:0] sat_mem(input acc_t v);
    logic signed [MEM_W-1:0] r;
    if (v > acc_t'(MEM_MAX)) begin
      r = MEM_W'(MEM_MAX);
    end else if (v < -acc_t'(MEM_MAX) - acc_t'(1)) begin
      r = ~MEM_W'(MEM_MAX);
    end else begin
      r = v[MEM_W-1:0];
    end
    return r;
  endfunction

  // Saturate to the sample width
  function automatic logic signed [SAMPLE_W-1:0] sat_smp(input acc_t v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > acc_t'(SMP_MAX)) begin
      r = SAMPLE_W'(SMP_MAX);
    end else if (v < -acc_t'(SMP_MAX) - acc_t'(1)) begin
      r = ~SAMPLE_W'(SMP_MAX);
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bit_crusher_lowpass_hold_unit.sv
// Top level of the bit crusher with lowpass and sample hold.
// Depends on bclh_pkg and bclh_sermul.
//
// One word is taken at a time; the next word is taken only after the result of
// the last one is registered. The work is done in two passes through 18-bit
// bit-serial multipliers, each a load step followed by one step per multiplier
// bit: b*q first, then a*y and y*mix_gain side by side. The rounded and
// saturated filter state and wet value are then registered, and a final step
// applies the hold and registers the result. A stall on the output keeps the
// finished word waiting until the output register is free. The user must write
// registers through the cfg port only while no word is in flight; the block
// does not enforce this, and the port is always ready. Channels beyond
// NUM_CHANNELS-1 share the last channel's filter and hold state. No clearing
// pass is needed after reset.
`default_nettype none

module bit_crusher_lowpass_hold_unit
  import bclh_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BX   = 2'd1;
  localparam logic [1:0] S_AY   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Configuration registers
  logic [DEPTH_W-1:0]        bit_depth;
  logic [HOLD_W-1:0]         hold_period;
  logic [GAIN_W-1:0]         mix_gain;
  logic [COEFB_W-1:0]        coef_b;
  logic signed [COEFA_W-1:0] coef_a;

  // Per-channel state
  logic signed [MEM_W-1:0]    filt_mem [NUM_CHANNELS];
  logic signed [SAMPLE_W-1:0] held_wet [NUM_CHANNELS];
  logic [HOLD_W-1:0]          phase    [NUM_CHANNELS];

  // Item registers
  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic                       chan_r;
  logic                       start_r;
  logic [CH_W-1:0]            ch_idx;
  logic signed [SAMPLE_W-1:0] x;
  logic signed [MUL_P_W-1:0]  bx;
  logic signed [MEM_W-1:0]    z_new;
  logic signed [SAMPLE_W-1:0] wet;

  logic                       accept;
  logic                       out_free;
  logic [CH_W-1:0]            ch_sel;
  mul_req_t                   req_a;
  mul_req_t                   req_b;
  mul_rsp_t                   rsp_a;
  mul_rsp_t                   rsp_b;
  logic signed [MEM_W-1:0]    y;
  acc_t                       sum_y;
  acc_t                       sum_z;
  acc_t                       sum_w;
  logic [HOLD_W-1:0]          hp;
  logic [HOLD_W-1:0]          p;
  logic [HOLD_W-1:0]          p_next;
  logic signed [SAMPLE_W-1:0] held_next;
  logic signed [SAMPLE_W-1:0] wet_sel;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // Channel select with fold onto the last channel
  always_comb begin
    if (32'(in_data.chan) < NUM_CHANNELS) begin
      ch_sel = CH_W'(in_data.chan);
    end else begin
      ch_sel = CH_W'(NUM_CHANNELS - 1);
    end
  end

  // Lowpass output and feedback / wet rounding
  always_comb begin
    sum_y = acc_t'(rsp_a.product) + (acc_t'(filt_mem[ch_idx]) <<< COEF_FRAC)
          + (acc_t'(1) <<< (COEF_FRAC - 1));
    y     = sat_mem(sum_y >>> COEF_FRAC);
    sum_z = acc_t'(bx) - acc_t'(rsp_a.product) + (acc_t'(1) <<< (COEF_FRAC - 1));
    sum_w = acc_t'(rsp_b.product) + (acc_t'(1) <<< (SAMPLE_W - 2));
  end

  // Multiplier requests
  always_comb begin
    req_a       = '0;
    req_b       = '0;
    req_b.mcand = y;
    req_b.mplr  = $signed({2'b00, mix_gain});
    if (state == S_IDLE) begin
      req_a.start = accept;
      req_a.mcand = MUL_M_W'(quantise(in_data.sample_in, bit_depth));
      req_a.mplr  = $signed({1'b0, coef_b});
    end else begin
      req_a.start = (state == S_BX) && rsp_a.done;
      req_a.mcand = y;
      req_a.mplr  = coef_a;
    end
    req_b.start = (state == S_BX) && rsp_a.done;
  end

  bclh_sermul u_mul_a (
    .clk (clk),
    .rst (rst),
    .req (req_a),
    .rsp (rsp_a)
  );

  bclh_sermul u_mul_b (
    .clk (clk),
    .rst (rst),
    .req (req_b),
    .rsp (rsp_b)
  );

  // Sample-rate reduction
  always_comb begin
    hp        = (hold_period > HOLD_W'(MAX_HOLD)) ? HOLD_W'(MAX_HOLD) : hold_period;
    p         = start_r ? '0 : phase[ch_idx];
    held_next = held_wet[ch_idx];
    if (hp >= HOLD_W'(2)) begin
      if (p >= hp) begin
        p = '0;
      end
      if (p == '0) begin
        held_next = wet;
      end
      wet_sel = held_next;
      p_next  = ((p + HOLD_W'(1)) == hp) ? '0 : p + HOLD_W'(1);
    end else begin
      held_next = wet;
      wet_sel   = wet;
      p_next    = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_BX;
      end
      S_BX: begin
        if (rsp_a.done) state_next = S_AY;
      end
      S_AY: begin
        if (rsp_a.done && rsp_b.done) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item capture and intermediate results
  always_ff @(posedge clk) begin
    if (accept) begin
      chan_r  <= in_data.chan;
      start_r <= in_data.block_start;
      ch_idx  <= ch_sel;
      x       <= in_data.sample_in;
    end
    if ((state == S_BX) && rsp_a.done) begin
      bx <= rsp_a.product;
    end
    if ((state == S_AY) && rsp_a.done) begin
      z_new <= sat_mem(sum_z >>> COEF_FRAC);
      wet   <= sat_smp(sum_w >>> (SAMPLE_W - 1));
    end
  end

  // Channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        filt_mem[i] <= '0;
        held_wet[i] <= '0;
        phase[i]    <= '0;
      end
    end else if ((state == S_FIN) && out_free) begin
      filt_mem[ch_idx] <= z_new;
      held_wet[ch_idx] <= held_next;
      phase[ch_idx]    <= p_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      out_data.chan_out   <= chan_r;
      out_data.sample_out <= sat_smp(acc_t'(x) + acc_t'(wet_sel));
    end
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_depth   <= BIT_DEPTH_RST;
      hold_period <= HOLD_PERIOD_RST;
      mix_gain    <= MIX_GAIN_RST;
      coef_b      <= COEF_B_RST;
      coef_a      <= COEF_A_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BIT_DEPTH:   bit_depth   <= cfg_data[DEPTH_W-1:0];
        REG_HOLD_PERIOD: hold_period <= cfg_data[HOLD_W-1:0];
        REG_MIX_GAIN:    mix_gain    <= cfg_data[GAIN_W-1:0];
        REG_COEF_B:      coef_b      <= cfg_data[COEFB_W-1:0];
        REG_COEF_A:      coef_a      <= $signed(cfg_data[COEFA_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/bclh_sermul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-right accumulator.
// Depends on bclh_pkg for widths and the request/response structs.
`default_nettype none

module bclh_sermul
  import bclh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  localparam int CNT_W = $clog2(MUL_R_W);

  logic                      busy;
  logic                      done;
  logic [CNT_W-1:0]          cnt;
  logic signed [MUL_M_W-1:0] mcand;
  logic [MUL_R_W-1:0]        mplr;
  logic signed [MUL_M_W:0]   hi;
  logic [MUL_R_W-1:0]        lo;

  logic                      last;
  logic signed [MUL_M_W+1:0] addend;
  logic signed [MUL_M_W+1:0] sum;

  // One partial product: the top multiplier bit carries negative weight
  always_comb begin
    last = (cnt == CNT_W'(MUL_R_W - 1));
    if (!mplr[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -(($bits(addend))'(mcand));
    end else begin
      addend = ($bits(addend))'(mcand);
    end
    sum = ($bits(sum))'(hi) + addend;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand <= req.mcand;
      mplr  <= req.mplr;
      hi    <= '0;
      lo    <= '0;
    end else if (busy) begin
      hi   <= sum[MUL_M_W+1:1];
      lo   <= {sum[0], lo[MUL_R_W-1:1]};
      mplr <= {1'b0, mplr[MUL_R_W-1:1]};
    end
  end

  assign rsp.done    = done;
  assign rsp.product = {hi, lo};

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for bit_crusher_lowpass_hold_unit.
// Depends on bclh_pkg and the RTL of the unit. An in-bench model of the crusher, the
// per-channel lowpass and the sample hold predicts every output word.

module tb
  import bclh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  bit_crusher_lowpass_hold_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model copy of the registers and the per-channel state
  longint cfg_depth, cfg_hold, cfg_gain, cfg_coef_b, cfg_coef_a;
  longint lp_state [2];
  longint wet_hold [2];
  int     hold_ph  [2];

  out_word_t due_q [$];
  int        mismatches = 0;
  int        burst_left = 0;
  bit        no_gaps = 1'b0;
  int        holds_wanted = 0;
  int        cycles = 0;

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // v / 2^s rounded half up
  function automatic longint round_up_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic void model_reset();
    cfg_depth  = BIT_DEPTH_RST;
    cfg_hold   = HOLD_PERIOD_RST;
    cfg_gain   = MIX_GAIN_RST;
    cfg_coef_b = COEF_B_RST;
    cfg_coef_a = COEF_A_RST;
    for (int i = 0; i < 2; i++) begin
      lp_state[i] = 0;
      wet_hold[i] = 0;
      hold_ph[i]  = 0;
    end
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    case (idx)
      REG_BIT_DEPTH:   cfg_depth  = d[DEPTH_W-1:0];
      REG_HOLD_PERIOD: cfg_hold   = d[HOLD_W-1:0];
      REG_MIX_GAIN:    cfg_gain   = d[GAIN_W-1:0];
      REG_COEF_B:      cfg_coef_b = d[COEFB_W-1:0];
      REG_COEF_A:      cfg_coef_a = $signed(d[COEFA_W-1:0]);
      default: ;
    endcase
  endfunction

  // Quantise, filter, scale, hold and add back to the dry sample
  function automatic out_word_t crush_predict(in_word_t w);
    out_word_t r;
    int        c, sh, hp, p;
    longint    x, q, bq, y, wet, res;
    c = w.chan;
    x = $signed(w.sample_in);
    q = x;
    if (cfg_depth < 15) begin
      sh = 15 - int'(cfg_depth);
      q = (x >>> sh) <<< sh;
    end
    bq = cfg_coef_b * q;
    y = clamp(round_up_shift(bq + (lp_state[c] <<< COEF_FRAC), COEF_FRAC), MEM_W);
    lp_state[c] = clamp(round_up_shift(bq - cfg_coef_a * y, COEF_FRAC), MEM_W);
    wet = clamp(round_up_shift(y * cfg_gain, 15), SAMPLE_W);
    hp = (cfg_hold > MAX_HOLD) ? MAX_HOLD : int'(cfg_hold);
    p = w.block_start ? 0 : hold_ph[c];
    if (hp >= 2) begin
      // phase left over from a longer period counts as a fresh block
      if (p >= hp) p = 0;
      if (p == 0) wet_hold[c] = wet;
      wet = wet_hold[c];
      p = (p + 1 == hp) ? 0 : p + 1;
    end else begin
      wet_hold[c] = wet;
      p = 0;
    end
    hold_ph[c] = p;
    res = clamp(x + wet, SAMPLE_W);
    r.chan_out   = w.chan;
    r.sample_out = res[SAMPLE_W-1:0];
    return r;
  endfunction

  // Offer one word in bursts with random gaps; predict it once taken
  task automatic send_word(input logic ch, input logic [SAMPLE_W-1:0] smp, input logic st);
    in_word_t w;
    int       gap;
    w.chan        = ch;
    w.sample_in   = smp;
    w.block_start = st;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    due_q.push_back(crush_predict(w));
  endtask

  // Stop offering and wait for every predicted word to come out
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (due_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    model_write(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_all(input logic [CFG_DAT_W-1:0] depth, input logic [CFG_DAT_W-1:0] hold,
                             input logic [CFG_DAT_W-1:0] gain, input logic [CFG_DAT_W-1:0] cb,
                             input logic [CFG_DAT_W-1:0] ca);
    cfg_write(REG_BIT_DEPTH, depth);
    cfg_write(REG_HOLD_PERIOD, hold);
    cfg_write(REG_MIX_GAIN, gain);
    cfg_write(REG_COEF_B, cb);
    cfg_write(REG_COEF_A, ca);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 127)) - 16'd64;
      default: return 16'($urandom);
    endcase
  endfunction

  // Output side: random stall patterns, plus long hold-offs on request
  always @(posedge clk) begin : stall_gen
    int stall_mode, mode_left, hold_left, holds_served;
    if (rst) begin
      out_stall <= 1'b0;
      mode_left = 0;
      hold_left = 0;
      holds_served = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != holds_wanted) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(50, 400);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 4) != 0);
        default: out_stall <= ((cycles % 7) < 3);
      endcase
    end
  end

  // Compare each output word with the oldest prediction
  always @(posedge clk) begin : check_out
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: chan %0d sample %0d", out_data.chan_out,
                   $signed(out_data.sample_out));
      end else begin
        want = due_q.pop_front();
        if (out_data.chan_out !== want.chan_out || out_data.sample_out !== want.sample_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected chan %0d sample %0d, got chan %0d sample %0d",
                     want.chan_out, $signed(want.sample_out), out_data.chan_out,
                     $signed(out_data.sample_out));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Reset values, full scale both ways, both channels
  task automatic test_defaults();
    send_word(1'b0, 16'h7FFF, 1'b1);
    send_word(1'b1, 16'h8000, 1'b1);
    send_word(1'b0, 16'h8000, 1'b0);
    send_word(1'b1, 16'h0001, 1'b0);
  endtask

  // Bit depth zero floors to -1 or 0; 15 and above pass the sample through
  task automatic test_quantiser();
    program_all(18'd0, 18'd0, 18'd32768, 18'd65536, 18'd0);
    send_word(1'b0, 16'h1234, 1'b0);
    send_word(1'b1, 16'h8123, 1'b0);
    cfg_write(REG_BIT_DEPTH, 18'd1);
    send_word(1'b0, 16'hC5A5, 1'b0);
    cfg_write(REG_BIT_DEPTH, 18'd14);
    send_word(1'b1, 16'hFFFF, 1'b0);
    cfg_write(REG_BIT_DEPTH, 18'd31);
    send_word(1'b0, 16'h5A5B, 1'b0);
  endtask

  // Hold behaviour, period lowered mid-block, period above the limit, period one
  task automatic test_hold();
    program_all(18'd8, 18'd4, 18'd20000, 18'd30000, 18'h3C000);
    send_word(1'b0, 16'h4000, 1'b1);
    send_word(1'b0, 16'hA000, 1'b0);
    send_word(1'b0, 16'h1111, 1'b0);
    cfg_write(REG_HOLD_PERIOD, 18'd6);
    send_word(1'b1, 16'h2222, 1'b1);
    send_word(1'b1, 16'h9999, 1'b0);
    send_word(1'b1, 16'h7000, 1'b0);
    cfg_write(REG_HOLD_PERIOD, 18'd2);
    send_word(1'b1, 16'h0F0F, 1'b0);
    cfg_write(REG_HOLD_PERIOD, 18'd63);
    send_word(1'b0, 16'h6000, 1'b1);
    send_word(1'b0, 16'h8001, 1'b0);
    cfg_write(REG_HOLD_PERIOD, 18'd1);
    send_word(1'b0, 16'h3333, 1'b0);
  endtask

  // Coefficient and gain extremes, and writes to unused indexes
  task automatic test_filter_extremes();
    program_all(18'd16, 18'd0, 18'd65535, 18'd131071, 18'h20000);
    send_word(1'b0, 16'h7FFF, 1'b0);
    send_word(1'b0, 16'h8000, 1'b0);
    program_all(18'd16, 18'd0, 18'd0, 18'd0, 18'h1FFFF);
    cfg_write(3'd5, 18'h3FFFF);
    cfg_write(3'd6, 18'h15555);
    cfg_write(3'd7, 18'h2AAAA);
    send_word(1'b1, 16'h7FFF, 1'b0);
  endtask

  task automatic configure_random();
    logic [CFG_DAT_W-1:0] depth, hold, gain, cb, ca;
    depth = CFG_DAT_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
                                                  : $urandom_range(0, 31));
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7:              hold = CFG_DAT_W'($urandom_range(0, 1));
      8, 9, 10, 11, 12, 13, 14, 15, 16:    hold = CFG_DAT_W'($urandom_range(2, 12));
      default:                             hold = CFG_DAT_W'($urandom_range(13, 63));
    endcase
    case ($urandom_range(0, 9))
      0:       gain = 18'd32768;
      1:       gain = CFG_DAT_W'($urandom_range(0, 65535));
      default: gain = CFG_DAT_W'($urandom_range(0, 32768));
    endcase
    cb = CFG_DAT_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 65536)
                                                : $urandom_range(0, 131071));
    // mostly stable filters, sometimes anything the field holds
    ca = ($urandom_range(0, 4) != 0) ? 18'($urandom_range(0, 131072)) - 18'd65536
                                     : 18'($urandom_range(0, 262143));
    program_all(depth, hold, gain, cb, ca);
  endtask

  // Mostly stereo blocks starting on block_start, some loose words
  task automatic run_words(input int n);
    int sent, len, hp;
    bit stereo;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 6) == 0) begin
        send_word(1'($urandom), rand_sample(), 1'($urandom));
        sent++;
      end else begin
        hp = (cfg_hold > MAX_HOLD) ? MAX_HOLD : int'(cfg_hold);
        len = $urandom_range(1, 2 * hp + 3);
        stereo = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len && sent < n; i++) begin
          send_word(1'b0, rand_sample(), i == 0);
          sent++;
          if (stereo && sent < n) begin
            send_word(1'b1, rand_sample(), i == 0);
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      configure_random();
      run_words(per_phase);
    end
  endtask

  // Output held off for a long stretch while words keep coming, then a full drain
  task automatic test_backpressure();
    program_all(18'd12, 18'd3, 18'd32768, 18'd40000, 18'h30000);
    no_gaps = 1'b1;
    holds_wanted++;
    run_words(30);
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_quantiser();
    test_hold();
    test_filter_extremes();

    // register extremes with random traffic
    program_all(18'd0, 18'd50, 18'd65535, 18'd131071, 18'h20000);
    run_words(60);
    program_all(18'd31, 18'd63, 18'd0, 18'd0, 18'h1FFFF);
    run_words(60);

    test_random_settings(6, 110);
    test_backpressure();
    test_random_settings(6, 110);

    drain();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && due_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
